@@ design/ihf_pkg.sv @@
// shared types and constants for the hex-float to ieee double converter
package ihf_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned FRAC_W = 56;
  localparam int unsigned EXP_W  = 11;
  localparam int unsigned MANT_W = 52;

  // base-2 bias less one, less four times the excess-64 offset of the source exponent
  localparam logic [EXP_W-1:0]  EXP_OFFSET = 11'd766;
  localparam logic [EXP_W-1:0]  EXP_MIN    = 11'd759;
  localparam logic [EXP_W-1:0]  EXP_MAX    = 11'd1274;
  localparam logic [WORD_W-1:0] NA_PATTERN = 64'h2E00_0000_0000_0000;

  typedef struct packed {
    logic [WORD_W-1:0] ibm_value;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] ieee_value;
    logic              na_flag;
    logic              last_out;
  } out_item_t;

endpackage

@@ design/ibm_hex_float_to_ieee_double_unit.sv @@
// top level: registered hex-float to ieee double converter
//
//  channel  | signals                        | direction | carries
//  ---------+--------------------------------+-----------+---------------------------
//  input    | in_valid, in_ready, in_data    | in        | ibm_value, last_in
//  result   | out_valid, out_ready, out_data | out       | ieee_value, na_flag, last_out
//
// one word per cycle sustained while out_ready stays high; a word passes from the input
// transfer through the input register and then the result register around the
// single conversion stage, and a stalled result can hold it between them
// synchronous active-low reset empties both registers
// a stalled result holds the pipe; the input register still fills while it
// is empty and the result waits
module ibm_hex_float_to_ieee_double_unit
  import ihf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t conv_res;
  logic      s2_take;
  logic      in_xfer;

  ihf_conv u_conv (
    .item_i (s1_data_r),
    .item_o (conv_res)
  );

  assign s2_take  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_take;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s2_take) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s2_take && s1_valid_r) begin
      out_data_r <= conv_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an na result always carries the fixed pattern
  a_na_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.na_flag) |-> (out_data_r.ieee_value == NA_PATTERN))
    else $error("na result without na pattern");

  // a normal nonzero result keeps its exponent in the reachable range
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.na_flag && (out_data_r.ieee_value != '0)) |->
      ((out_data_r.ieee_value[62:52] >= EXP_MIN) &&
       (out_data_r.ieee_value[62:52] <= EXP_MAX)))
    else $error("result exponent out of range");

  // a held input word moves to the result register when it is free
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_take) |=> out_valid_r)
    else $error("input word lost on advance");

  // the input register never overwrites a word that has not moved on
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_take) |-> !in_ready)
    else $error("input register overwrite");

endmodule

@@ design/ihf_conv.sv @@
// combinational hex-float to ieee double conversion of one word
module ihf_conv
  import ihf_pkg::*;
(
  input  in_item_t  item_i,
  output out_item_t item_o
);

  logic [FRAC_W-1:0] frac;
  logic [FRAC_W-1:0] shifted;
  logic [FRAC_W-1:0] norm;
  logic              top_zero;
  logic              second_zero;
  logic [1:0]        lead;
  logic [EXP_W-1:0]  exp_field;
  logic [EXP_W-1:0]  nib_adj;

  always_comb begin
    frac        = item_i.ibm_value[FRAC_W-1:0];
    top_zero    = (frac[55:52] == 4'd0);
    second_zero = (frac[51:48] == 4'd0);
    // one nibble retry when the top nibble is empty
    shifted     = top_zero ? {frac[51:0], 4'b0000} : frac;
    nib_adj     = top_zero ? 11'd4 : 11'd0;

    casez (shifted[55:52])
      4'b1???: lead = 2'd0;
      4'b01??: lead = 2'd1;
      4'b001?: lead = 2'd2;
      default: lead = 2'd3;
    endcase

    norm      = shifted << lead;
    exp_field = {2'b00, item_i.ibm_value[62:56], 2'b00} + EXP_OFFSET
                - {9'd0, lead} - nib_adj;

    item_o.last_out = item_i.last_in;
    if (item_i.ibm_value == '0) begin
      item_o.ieee_value = '0;
      item_o.na_flag    = 1'b0;
    end else if (top_zero && second_zero) begin
      item_o.ieee_value = NA_PATTERN;
      item_o.na_flag    = 1'b1;
    end else begin
      // leading one at bit 55 becomes the hidden bit, low bits truncated
      item_o.ieee_value = {item_i.ibm_value[63], exp_field, norm[54:3]};
      item_o.na_flag    = 1'b0;
    end
  end

endmodule
